### design/bba_pkg.sv
// Package for the buddy block allocator: default geometry, field widths,
// result codes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  // Default geometry
  localparam int HEAP_BYTES_DEF     = 65536;
  localparam int MIN_BLOCK_LOG2_DEF = 5;
  localparam int ORDERS_DEF         = 11;
  localparam int HEADER_BYTES_DEF   = 24;

  // Field widths
  localparam int ADDR_W    = 48;
  localparam int REQ_W     = 16;
  localparam int ORDER_W   = 4;
  localparam int MARK_W    = 5;
  localparam int WORD_W    = 32;
  localparam int WORD_LOG2 = 5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_SPLIT_RD,
    OP_SPLIT_WR,
    OP_MARK_WR,
    OP_MARK_RD,
    OP_FREE_INIT,
    OP_LVL_RD,
    OP_LVL_WR,
    OP_DONE_OK,
    OP_DONE_FAIL
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic too_large;
    logic free_bad;
    logic hit;
    logic scan_last;
    logic split_more;
    logic mark_bad;
    logic merge;
  } dp_stat_t;

endpackage
`default_nettype wire

### design/bba_datapath.sv
// Datapath of the buddy block allocator: free bitmap memory, allocation
// mark memory, working registers and result registers.
// Depends on bba_pkg; driven by bba_controller.
`timescale 1ns / 1ps
`default_nettype none
module bba_datapath #(
  parameter int HEAP_BYTES     = bba_pkg::HEAP_BYTES_DEF,
  parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2_DEF,
  parameter int ORDERS         = bba_pkg::ORDERS_DEF,
  parameter int HEADER_BYTES   = bba_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bba_pkg::dp_cmd_t            cmd_i,
  output bba_pkg::dp_stat_t                stat_o,
  input  wire logic                        command_i,
  input  wire logic [bba_pkg::REQ_W-1:0]   request_bytes_i,
  input  wire logic [bba_pkg::ADDR_W-1:0]  free_address_i,
  input  wire logic                        heap_base_we_i,
  input  wire logic [bba_pkg::ADDR_W-1:0]  heap_base_i,
  output logic                             done_o,
  output logic [bba_pkg::ADDR_W-1:0]       payload_address_o,
  output logic [bba_pkg::ORDER_W-1:0]      block_order_o,
  output logic [1:0]                       status_o
);

  localparam int SLOTS      = HEAP_BYTES >> MIN_BLOCK_LOG2;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W      = (SLOT_W > 6) ? SLOT_W : 6;
  localparam int WORDS0     = (SLOTS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
  localparam int WW         = (WORDS0 > 1) ? $clog2(WORDS0) : 1;
  localparam int OW         = (ORDERS > 1) ? $clog2(ORDERS) : 1;
  localparam int FAW        = OW + WW;
  localparam int FREE_DEPTH = ORDERS * (1 << WW);
  localparam int CLR_N      = (FREE_DEPTH > SLOTS) ? FREE_DEPTH : SLOTS;
  localparam int CLR_W      = $clog2(CLR_N + 1);
  localparam int TOP_LOG2   = MIN_BLOCK_LOG2 + ORDERS - 1;
  localparam int N_TOP      = SLOTS >> (ORDERS - 1);
  localparam int NEED_W     = bba_pkg::REQ_W + 1;
  localparam logic [bba_pkg::ADDR_W-1:0] ALIGN_MASK =
    bba_pkg::ADDR_W'((64'd1 << MIN_BLOCK_LOG2) - 64'd1);
  localparam logic [OW-1:0] TOP_O = OW'(ORDERS - 1);

  // Blocks at an order
  function automatic logic [SLOT_W:0] n_at(input logic [OW-1:0] o);
    n_at = (SLOT_W + 1)'(SLOTS) >> o;
  endfunction

  // Last bitmap word of an order
  function automatic logic [WW-1:0] last_word(input logic [OW-1:0] o);
    logic [SLOT_W:0] n;
    n = n_at(o);
    if (n == '0) last_word = '0;
    else         last_word = WW'((n - 1'b1) >> bba_pkg::WORD_LOG2);
  endfunction

  // Reset contents of one bitmap word: top-order blocks free
  function automatic logic [bba_pkg::WORD_W-1:0] init_word(input logic [FAW-1:0] a);
    int base;
    int cnt;
    logic [bba_pkg::WORD_W-1:0] m;
    base = int'(a[WW-1:0]) << bba_pkg::WORD_LOG2;
    cnt  = N_TOP - base;
    m    = '0;
    if (a[FAW-1:WW] == TOP_O) begin
      if (cnt >= bba_pkg::WORD_W) m = '1;
      else if (cnt > 0)           m = bba_pkg::WORD_W'((64'd1 << cnt) - 64'd1);
    end
    init_word = m;
  endfunction

  function automatic logic [WW-1:0] word_of(input logic [IDX_W-1:0] idx);
    word_of = WW'(idx >> bba_pkg::WORD_LOG2);
  endfunction

  // Registers
  logic [bba_pkg::ADDR_W-1:0]  base_q;
  logic                        is_free_q;
  logic [NEED_W-1:0]           need_q;
  logic [OW-1:0]               omin_q, o_q;
  logic [WW-1:0]               w_q;
  logic [IDX_W-1:0]            idx_q;
  logic [SLOT_W-1:0]           slot_q;
  logic [bba_pkg::ADDR_W-1:0]  offset_q;
  logic [bba_pkg::ORDER_W-1:0] res_order_q;
  logic [CLR_W-1:0]            clr_q;
  logic [bba_pkg::WORD_W-1:0]  fword_q;
  logic [bba_pkg::MARK_W-1:0]  mark_q;
  logic                        done_q;
  logic [bba_pkg::ADDR_W-1:0]  pay_q;
  logic [bba_pkg::ORDER_W-1:0] ord_q;
  bba_pkg::status_e            stat_q;

  logic [bba_pkg::WORD_W-1:0] fmem [FREE_DEPTH];
  logic [bba_pkg::MARK_W-1:0] mmem [SLOTS];

  // Input decode for a new transaction
  logic [NEED_W-1:0]          need_d;
  logic [OW-1:0]              omin_d;
  logic [bba_pkg::ADDR_W-1:0] foff_d;

  always_comb begin
    need_d = NEED_W'(request_bytes_i) + NEED_W'(HEADER_BYTES);
    foff_d = free_address_i - base_q - bba_pkg::ADDR_W'(HEADER_BYTES);
    omin_d = TOP_O;
    for (int o = ORDERS - 1; o >= 0; o--) begin
      if ((64'd1 << (MIN_BLOCK_LOG2 + o)) >= 64'(need_d)) omin_d = OW'(o);
    end
  end

  // Lowest free block within the word just read
  logic [bba_pkg::WORD_LOG2-1:0] pe;
  always_comb begin
    pe = '0;
    for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (fword_q[i]) pe = bba_pkg::WORD_LOG2'(i);
    end
  end

  logic [IDX_W-1:0]  buddy;
  logic [SLOT_W-1:0] slot_alloc;
  logic [OW-1:0]     mark_o;
  logic              hit, merge, word_end;

  assign buddy      = idx_q ^ IDX_W'(1);
  assign slot_alloc = SLOT_W'(idx_q << o_q);
  assign mark_o     = OW'(mark_q - 1'b1);
  assign hit        = fword_q != '0;
  assign word_end   = w_q == last_word(o_q);
  assign merge      = (o_q != TOP_O) &&
                      ((IDX_W + 1)'(buddy) < (IDX_W + 1)'(n_at(o_q))) &&
                      fword_q[buddy[bba_pkg::WORD_LOG2-1:0]];

  // Status back to the controller
  always_comb begin
    stat_o.clear_last = clr_q == CLR_W'(CLR_N - 1);
    stat_o.is_free    = is_free_q;
    stat_o.too_large  = 64'(need_q) > (64'd1 << TOP_LOG2);
    stat_o.free_bad   = ((offset_q >> MIN_BLOCK_LOG2) >= bba_pkg::ADDR_W'(SLOTS)) ||
                        ((offset_q & ALIGN_MASK) != '0);
    stat_o.hit        = hit;
    stat_o.scan_last  = (o_q == TOP_O) && word_end;
    stat_o.split_more = o_q != omin_q;
    stat_o.mark_bad   = (mark_q == '0) || (mark_q > bba_pkg::MARK_W'(ORDERS));
    stat_o.merge      = merge;
  end

  // Memory port selection
  logic                       f_we, f_re, m_we, m_re;
  logic [FAW-1:0]             f_wa, f_ra;
  logic [bba_pkg::WORD_W-1:0] f_wd;
  logic [SLOT_W-1:0]          m_wa, m_ra;
  logic [bba_pkg::MARK_W-1:0] m_wd;
  logic [bba_pkg::WORD_W-1:0] bit_idx, bit_bud, bit_odd;

  assign bit_idx = bba_pkg::WORD_W'(1) << idx_q[bba_pkg::WORD_LOG2-1:0];
  assign bit_bud = bba_pkg::WORD_W'(1) << buddy[bba_pkg::WORD_LOG2-1:0];
  assign bit_odd = bba_pkg::WORD_W'(1) << (idx_q[bba_pkg::WORD_LOG2-1:0] | 5'd1);

  always_comb begin
    f_we = 1'b0; f_re = 1'b0; m_we = 1'b0; m_re = 1'b0;
    f_wa = {o_q, word_of(idx_q)};
    f_ra = {o_q, w_q};
    f_wd = '0;
    m_wa = slot_q;
    m_ra = slot_q;
    m_wd = '0;
    unique case (cmd_i.op)
      bba_pkg::OP_CLEAR: begin
        f_we = clr_q < CLR_W'(FREE_DEPTH);
        f_wa = FAW'(clr_q);
        f_wd = init_word(FAW'(clr_q));
        m_we = clr_q < CLR_W'(SLOTS);
        m_wa = SLOT_W'(clr_q);
      end
      bba_pkg::OP_SCAN_RD: f_re = 1'b1;
      bba_pkg::OP_SCAN_CHK: begin
        f_we = hit;
        f_wa = {o_q, w_q};
        f_wd = fword_q & ~(bba_pkg::WORD_W'(1) << pe);
      end
      bba_pkg::OP_SPLIT_RD: begin
        f_re = 1'b1;
        f_ra = {o_q - 1'b1, word_of(idx_q << 1)};
      end
      bba_pkg::OP_SPLIT_WR: begin
        f_we = 1'b1;
        f_wd = fword_q | bit_odd;
      end
      bba_pkg::OP_MARK_WR: begin
        m_we = 1'b1;
        m_wa = slot_alloc;
        m_wd = bba_pkg::MARK_W'(o_q) + 1'b1;
      end
      bba_pkg::OP_MARK_RD:   m_re = 1'b1;
      bba_pkg::OP_FREE_INIT: m_we = 1'b1;
      bba_pkg::OP_LVL_RD: begin
        f_re = 1'b1;
        f_ra = {o_q, word_of(idx_q)};
      end
      bba_pkg::OP_LVL_WR: begin
        f_we = 1'b1;
        f_wd = merge ? (fword_q & ~(bit_idx | bit_bud)) : (fword_q | bit_idx);
      end
      default: ;
    endcase
  end

  // Free bitmap memory
  always_ff @(posedge clk_i) begin
    if (f_we) fmem[f_wa] <= f_wd;
    if (f_re) fword_q <= fmem[f_ra];
  end

  // Allocation mark memory
  always_ff @(posedge clk_i) begin
    if (m_we) mmem[m_wa] <= m_wd;
    if (m_re) mark_q <= mmem[m_ra];
  end

  // Configuration and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      if (heap_base_we_i) base_q <= heap_base_i;
      if (cmd_i.op == bba_pkg::OP_CLEAR) clr_q <= clr_q + 1'b1;
      done_q <= (cmd_i.op == bba_pkg::OP_DONE_OK) || (cmd_i.op == bba_pkg::OP_DONE_FAIL);
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      bba_pkg::OP_LOAD: begin
        is_free_q <= command_i;
        need_q    <= need_d;
        omin_q    <= omin_d;
        o_q       <= omin_d;
        w_q       <= '0;
        offset_q  <= foff_d;
        slot_q    <= SLOT_W'(foff_d >> MIN_BLOCK_LOG2);
      end
      bba_pkg::OP_SCAN_CHK: begin
        if (hit) begin
          idx_q <= IDX_W'({w_q, pe});
        end else if (word_end) begin
          o_q <= o_q + 1'b1;
          w_q <= '0;
        end else begin
          w_q <= w_q + 1'b1;
        end
      end
      bba_pkg::OP_SPLIT_RD: begin
        o_q   <= o_q - 1'b1;
        idx_q <= idx_q << 1;
      end
      bba_pkg::OP_MARK_WR: begin
        offset_q    <= bba_pkg::ADDR_W'(slot_alloc) << MIN_BLOCK_LOG2;
        res_order_q <= bba_pkg::ORDER_W'(o_q);
      end
      bba_pkg::OP_FREE_INIT: begin
        o_q         <= mark_o;
        idx_q       <= IDX_W'(slot_q >> mark_o);
        res_order_q <= bba_pkg::ORDER_W'(mark_q - 1'b1);
      end
      bba_pkg::OP_LVL_WR: begin
        if (merge) begin
          o_q   <= o_q + 1'b1;
          idx_q <= idx_q >> 1;
        end
      end
      bba_pkg::OP_DONE_OK: begin
        pay_q  <= base_q + offset_q + bba_pkg::ADDR_W'(HEADER_BYTES);
        ord_q  <= res_order_q;
        stat_q <= bba_pkg::ST_OK;
      end
      bba_pkg::OP_DONE_FAIL: begin
        pay_q  <= '0;
        ord_q  <= '0;
        stat_q <= cmd_i.code;
      end
      default: ;
    endcase
  end

  assign done_o            = done_q;
  assign payload_address_o = pay_q;
  assign block_order_o     = ord_q;
  assign status_o          = stat_q;

endmodule
`default_nettype wire

### design/bba_controller.sv
// Controller of the buddy block allocator: sequences clearing, allocate
// scan/split and free/merge steps through datapath commands.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bba_controller (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire bba_pkg::dp_stat_t stat_i,
  output bba_pkg::dp_cmd_t       cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_A_RD  = 4'd3;
  localparam logic [3:0] S_A_CHK = 4'd4;
  localparam logic [3:0] S_SP_RD = 4'd5;
  localparam logic [3:0] S_SP_WR = 4'd6;
  localparam logic [3:0] S_MARK  = 4'd7;
  localparam logic [3:0] S_F_RD  = 4'd8;
  localparam logic [3:0] S_F_CHK = 4'd9;
  localparam logic [3:0] S_LV_RD = 4'd10;
  localparam logic [3:0] S_LV_WR = 4'd11;
  localparam logic [3:0] S_OK    = 4'd12;

  logic [3:0] state_q, state_d;

  // Next state and datapath command
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = bba_pkg::OP_NONE;
    cmd_o.code = bba_pkg::ST_OK;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = bba_pkg::OP_CLEAR;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.op = bba_pkg::OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.is_free) begin
          if (stat_i.free_bad) begin
            cmd_o.op   = bba_pkg::OP_DONE_FAIL;
            cmd_o.code = bba_pkg::ST_BAD_FREE;
            state_d    = S_IDLE;
          end else begin
            state_d = S_F_RD;
          end
        end else if (stat_i.too_large) begin
          cmd_o.op   = bba_pkg::OP_DONE_FAIL;
          cmd_o.code = bba_pkg::ST_TOO_LARGE;
          state_d    = S_IDLE;
        end else begin
          state_d = S_A_RD;
        end
      end
      S_A_RD: begin
        cmd_o.op = bba_pkg::OP_SCAN_RD;
        state_d  = S_A_CHK;
      end
      S_A_CHK: begin
        cmd_o.op = bba_pkg::OP_SCAN_CHK;
        if (stat_i.hit) begin
          state_d = stat_i.split_more ? S_SP_RD : S_MARK;
        end else if (stat_i.scan_last) begin
          cmd_o.op   = bba_pkg::OP_DONE_FAIL;
          cmd_o.code = bba_pkg::ST_NO_FREE;
          state_d    = S_IDLE;
        end else begin
          state_d = S_A_RD;
        end
      end
      S_SP_RD: begin
        cmd_o.op = bba_pkg::OP_SPLIT_RD;
        state_d  = S_SP_WR;
      end
      S_SP_WR: begin
        cmd_o.op = bba_pkg::OP_SPLIT_WR;
        state_d  = stat_i.split_more ? S_SP_RD : S_MARK;
      end
      S_MARK: begin
        cmd_o.op = bba_pkg::OP_MARK_WR;
        state_d  = S_OK;
      end
      S_F_RD: begin
        cmd_o.op = bba_pkg::OP_MARK_RD;
        state_d  = S_F_CHK;
      end
      S_F_CHK: begin
        if (stat_i.mark_bad) begin
          cmd_o.op   = bba_pkg::OP_DONE_FAIL;
          cmd_o.code = bba_pkg::ST_BAD_FREE;
          state_d    = S_IDLE;
        end else begin
          cmd_o.op = bba_pkg::OP_FREE_INIT;
          state_d  = S_LV_RD;
        end
      end
      S_LV_RD: begin
        cmd_o.op = bba_pkg::OP_LVL_RD;
        state_d  = S_LV_WR;
      end
      S_LV_WR: begin
        cmd_o.op = bba_pkg::OP_LVL_WR;
        state_d  = stat_i.merge ? S_LV_RD : S_OK;
      end
      S_OK: begin
        cmd_o.op = bba_pkg::OP_DONE_OK;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  assign busy = state_q != S_IDLE;

endmodule
`default_nettype wire

### design/buddy_block_allocator.sv
// Top level of the buddy block allocator: controller plus datapath.
// Depends on bba_pkg, bba_controller, bba_datapath.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------------
//  command   | start / busy           | command_i, request_bytes_i, free_address_i
//  result    | done_o (1-cycle pulse) | payload_address_o, block_order_o, status_o
//  config    | heap_base_we_i         | heap_base_i
//
// Allocate scans the free bitmap word by word, reading then checking each
// word, from the smallest fitting order upward, then splits down block by
// block. Free reads the allocation mark, then reads and writes the bitmap
// once per merge level. Rejected commands never touch the free bitmap; an
// allocate that finds no free block ends after the word scan of the top
// order. After reset a clearing pass of both memories runs with busy high.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator #(
  parameter int HEAP_BYTES     = bba_pkg::HEAP_BYTES_DEF,
  parameter int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2_DEF,
  parameter int ORDERS         = bba_pkg::ORDERS_DEF,
  parameter int HEADER_BYTES   = bba_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       command_i,
  input  wire logic [bba_pkg::REQ_W-1:0]  request_bytes_i,
  input  wire logic [bba_pkg::ADDR_W-1:0] free_address_i,
  input  wire logic                       heap_base_we_i,
  input  wire logic [bba_pkg::ADDR_W-1:0] heap_base_i,
  output logic                            done_o,
  output logic [bba_pkg::ADDR_W-1:0]      payload_address_o,
  output logic [bba_pkg::ORDER_W-1:0]     block_order_o,
  output logic [1:0]                      status_o
);

  bba_pkg::dp_cmd_t  cmd;
  bba_pkg::dp_stat_t stat;

  bba_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bba_datapath #(
    .HEAP_BYTES     (HEAP_BYTES),
    .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
    .ORDERS         (ORDERS),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .command_i         (command_i),
    .request_bytes_i   (request_bytes_i),
    .free_address_i    (free_address_i),
    .heap_base_we_i    (heap_base_we_i),
    .heap_base_i       (heap_base_i),
    .done_o            (done_o),
    .payload_address_o (payload_address_o),
    .block_order_o     (block_order_o),
    .status_o          (status_o)
  );

endmodule
`default_nettype wire

### design/bba_checker.sv
// Port-level checks for the buddy block allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator.
`timescale 1ns / 1ps
`default_nettype none
module bba_checker #(
  parameter int ORDERS = bba_pkg::ORDERS_DEF
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic [bba_pkg::ADDR_W-1:0]  payload_address_o,
  input wire logic [bba_pkg::ORDER_W-1:0] block_order_o,
  input wire logic [1:0]                  status_o
);

  // Accepted transaction keeps the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accepted command");

  // A result only arrives once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  // One pulse per result
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");

  // Failures return zero fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bba_pkg::ST_OK) |->
      (payload_address_o == '0 && block_order_o == '0))
    else $error("failure result carries data");

  // Orders stay in range
  a_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == bba_pkg::ST_OK) |->
      (block_order_o < bba_pkg::ORDER_W'(ORDERS)))
    else $error("block order out of range");

endmodule

bind buddy_block_allocator bba_checker #(.ORDERS(ORDERS)) u_bba_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .done_o            (done_o),
  .payload_address_o (payload_address_o),
  .block_order_o     (block_order_o),
  .status_o          (status_o)
);
`default_nettype wire

### tb/tb_buddy_block_allocator.sv
// Self-checking testbench for buddy_block_allocator: a directed table, then
// randomized allocate/free traffic checked against an in-bench buddy predictor.
// Depends on bba_pkg and the buddy_block_allocator RTL.
`timescale 1ns / 1ps
module tb_buddy_block_allocator;

  localparam int HEAP   = 65536;
  localparam int MINLG  = 5;
  localparam int NORD   = 11;
  localparam int HDR    = 24;
  localparam int NSLOT  = HEAP >> MINLG;
  localparam int TOPSZ  = 1 << (MINLG + NORD - 1);
  localparam int SETTLE = 50;

  typedef struct packed {
    logic [bba_pkg::ADDR_W-1:0]  addr;
    logic [bba_pkg::ORDER_W-1:0] order;
    bba_pkg::status_e            st;
  } alloc_result_t;

  typedef struct packed {
    bba_pkg::command_e          cmd;
    logic [bba_pkg::REQ_W-1:0]  req;
    logic [bba_pkg::ADDR_W-1:0] faddr;
    logic                       typed;
    alloc_result_t              res;
  } stim_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         command_i = 1'b0;
  logic [bba_pkg::REQ_W-1:0]    request_bytes_i = '0;
  logic [bba_pkg::ADDR_W-1:0]   free_address_i = '0;
  logic                         heap_base_we_i = 1'b0;
  logic [bba_pkg::ADDR_W-1:0]   heap_base_i = '0;
  logic                         done_o;
  logic [bba_pkg::ADDR_W-1:0]   payload_address_o;
  logic [bba_pkg::ORDER_W-1:0]  block_order_o;
  logic [1:0]                   status_o;

  buddy_block_allocator u_top (
    .clk_i, .rst_ni, .start, .busy, .command_i, .request_bytes_i, .free_address_i,
    .heap_base_we_i, .heap_base_i, .done_o, .payload_address_o, .block_order_o,
    .status_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  bit                         free_bits [NORD][NSLOT];
  logic [bba_pkg::MARK_W-1:0] block_mark [NSLOT];
  logic [bba_pkg::ADDR_W-1:0] base_addr;
  alloc_result_t              pending_results [$];
  int unsigned                live_offsets [$];
  int                         err_cnt = 0;
  int                         send_idle_pct = 0;

  localparam stim_row_t DIRECTED [19] = '{
    '{bba_pkg::CMD_ALLOC, 16'd0,     48'd0,     1'b1, '{48'd24,    4'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 16'hFFFF,  48'd0,     1'b1,
      '{48'd0, 4'd0, bba_pkg::ST_TOO_LARGE}},
    '{bba_pkg::CMD_ALLOC, 16'd32744, 48'd0,     1'b1, '{48'd32792, 4'd10, bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 16'd32745, 48'd0,     1'b1,
      '{48'd0, 4'd0, bba_pkg::ST_TOO_LARGE}},
    '{bba_pkg::CMD_FREE,  16'd0,     48'd0,     1'b1, '{48'd0, 4'd0, bba_pkg::ST_BAD_FREE}},
    '{bba_pkg::CMD_FREE,  16'd0,     48'd25,    1'b1, '{48'd0, 4'd0, bba_pkg::ST_BAD_FREE}},
    '{bba_pkg::CMD_FREE,  16'hFFFF,  {bba_pkg::ADDR_W{1'b1}}, 1'b1,
      '{48'd0, 4'd0, bba_pkg::ST_BAD_FREE}},
    '{bba_pkg::CMD_FREE,  16'd0,     48'd65560, 1'b1, '{48'd0, 4'd0, bba_pkg::ST_BAD_FREE}},
    '{bba_pkg::CMD_ALLOC, 16'd8,     48'd0,     1'b0, '{48'd0,     4'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 16'd9,     48'd0,     1'b0, '{48'd0,     4'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  16'd0,     48'd24,    1'b1, '{48'd24,    4'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  16'd0,     48'd24,    1'b1, '{48'd0, 4'd0, bba_pkg::ST_BAD_FREE}},
    '{bba_pkg::CMD_FREE,  16'd0,     48'd56,    1'b0, '{48'd0,     4'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  16'd0,     48'd88,    1'b0, '{48'd0,     4'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  16'd0,     48'd32792, 1'b1, '{48'd32792, 4'd10, bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 16'd32744, 48'd0,     1'b0, '{48'd0,     4'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 16'd32744, 48'd0,     1'b0, '{48'd0,     4'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 16'd32744, 48'd0,     1'b1, '{48'd0, 4'd0, bba_pkg::ST_NO_FREE}},
    '{bba_pkg::CMD_FREE,  16'd0,     48'd24,    1'b0, '{48'd0,     4'd0,  bba_pkg::ST_OK}}
  };

  function automatic void reset_heap();
    foreach (free_bits[o, i]) free_bits[o][i] = 1'b0;
    foreach (block_mark[i]) block_mark[i] = '0;
    for (int i = 0; i < (HEAP >> (MINLG + NORD - 1)); i++) free_bits[NORD-1][i] = 1'b1;
    base_addr = '0;
  endfunction

  // Allocate: smallest fitting order with a free block, lowest address, split down
  function automatic alloc_result_t predict_alloc(logic [bba_pkg::REQ_W-1:0] req);
    int need;
    int o;
    int idx;
    bit found;
    logic [bba_pkg::ADDR_W-1:0] offs;
    need = int'(req) + HDR;
    found = 1'b0;
    idx = 0;
    if (need > TOPSZ) return '{'0, '0, bba_pkg::ST_TOO_LARGE};
    for (o = 0; o < NORD && !found; o++) begin
      if ((1 << (MINLG + o)) >= need) begin
        for (int i = 0; i < (HEAP >> (MINLG + o)) && !found; i++) begin
          if (free_bits[o][i]) begin
            found = 1'b1;
            idx = i;
          end
        end
      end
      if (found) break;
    end
    if (!found) return '{'0, '0, bba_pkg::ST_NO_FREE};
    free_bits[o][idx] = 1'b0;
    while (o > 0 && (1 << (MINLG + o - 1)) >= need) begin
      o--;
      idx = idx << 1;
      free_bits[o][idx+1] = 1'b1;
    end
    offs = bba_pkg::ADDR_W'(idx) << (MINLG + o);
    block_mark[offs >> MINLG] = bba_pkg::MARK_W'(o + 1);
    live_offsets.push_back(int'(offs));
    return '{base_addr + offs + bba_pkg::ADDR_W'(HDR), bba_pkg::ORDER_W'(o), bba_pkg::ST_OK};
  endfunction

  // Free: validate, clear the mark, merge with the true buddy level by level
  function automatic alloc_result_t predict_free(logic [bba_pkg::ADDR_W-1:0] addr);
    logic [bba_pkg::ADDR_W-1:0] offs;
    int slot;
    int o;
    int freed;
    int idx;
    offs = addr - base_addr - bba_pkg::ADDR_W'(HDR);
    if (offs >= bba_pkg::ADDR_W'(HEAP) || offs[MINLG-1:0] != '0)
      return '{'0, '0, bba_pkg::ST_BAD_FREE};
    slot = int'(offs >> MINLG);
    if (block_mark[slot] == '0 || block_mark[slot] > NORD)
      return '{'0, '0, bba_pkg::ST_BAD_FREE};
    o = int'(block_mark[slot]) - 1;
    freed = o;
    block_mark[slot] = '0;
    idx = slot >> o;
    free_bits[o][idx] = 1'b1;
    while (o < NORD - 1) begin
      if ((idx ^ 1) >= (HEAP >> (MINLG + o)) || !free_bits[o][idx^1]) break;
      free_bits[o][idx] = 1'b0;
      free_bits[o][idx^1] = 1'b0;
      idx = idx >> 1;
      o++;
      free_bits[o][idx] = 1'b1;
    end
    return '{addr, bba_pkg::ORDER_W'(freed), bba_pkg::ST_OK};
  endfunction

  // One command transaction; the predictor runs at the accepting edge
  task automatic send_cmd(bba_pkg::command_e cmd, logic [bba_pkg::REQ_W-1:0] req,
                          logic [bba_pkg::ADDR_W-1:0] faddr,
                          bit typed, alloc_result_t typed_res);
    alloc_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    start           <= 1'b1;
    command_i       <= cmd;
    request_bytes_i <= req;
    free_address_i  <= faddr;
    do @(posedge clk_i); while (busy);
    res = (cmd == bba_pkg::CMD_ALLOC) ? predict_alloc(req) : predict_free(faddr);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // Quiesce: drop start, drain results, let the block settle
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_base(logic [bba_pkg::ADDR_W-1:0] val);
    heap_base_we_i <= 1'b1;
    heap_base_i    <= val;
    @(posedge clk_i);
    heap_base_we_i <= 1'b0;
    base_addr = val;
  endtask

  task automatic random_phase(int n_items);
    int kind;
    int pick;
    logic [bba_pkg::REQ_W-1:0] req;
    logic [bba_pkg::ADDR_W-1:0] faddr;
    for (int k = 0; k < n_items; k++) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        // mostly small requests, some of any size
        case ($urandom_range(3))
          0: req = bba_pkg::REQ_W'($urandom_range(40));
          1: req = bba_pkg::REQ_W'($urandom_range(1000));
          2: req = bba_pkg::REQ_W'($urandom_range(8000));
          default: req = bba_pkg::REQ_W'($urandom);
        endcase
        send_cmd(bba_pkg::CMD_ALLOC, req, bba_pkg::ADDR_W'($urandom), 1'b0, '0);
      end else if (kind < 85 && live_offsets.size() != 0) begin
        pick = $urandom_range(live_offsets.size() - 1);
        faddr = base_addr + bba_pkg::ADDR_W'(live_offsets[pick]) + bba_pkg::ADDR_W'(HDR);
        live_offsets.delete(pick);
        send_cmd(bba_pkg::CMD_FREE, bba_pkg::REQ_W'($urandom), faddr, 1'b0, '0);
      end else begin
        // mostly bad frees: random address, near-miss, or a random slot start
        case ($urandom_range(2))
          0: faddr = bba_pkg::ADDR_W'({$urandom, $urandom});
          1: faddr = base_addr + bba_pkg::ADDR_W'(HDR) +
                     bba_pkg::ADDR_W'($urandom_range(HEAP + 64));
          default: faddr = base_addr + bba_pkg::ADDR_W'(HDR) +
                           (bba_pkg::ADDR_W'($urandom_range(NSLOT)) << MINLG);
        endcase
        send_cmd(bba_pkg::CMD_FREE, bba_pkg::REQ_W'($urandom), faddr, 1'b0, '0);
      end
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    alloc_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding: addr %h", payload_address_o);
        err_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (payload_address_o !== exp_res.addr) begin
          $error("payload_address: expected %h, got %h", exp_res.addr, payload_address_o);
          err_cnt++;
        end
        if (block_order_o !== exp_res.order) begin
          $error("block_order: expected %0d, got %0d", exp_res.order, block_order_o);
          err_cnt++;
        end
        if (status_o !== exp_res.st) begin
          $error("status: expected %0d, got %0d", exp_res.st, status_o);
          err_cnt++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    reset_heap();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_base('0);

    foreach (DIRECTED[r])
      send_cmd(DIRECTED[r].cmd, DIRECTED[r].req, DIRECTED[r].faddr,
               DIRECTED[r].typed, DIRECTED[r].res);
    live_offsets.delete();
    live_offsets.push_back(32768);
    drain();

    // address wrap at the top of the address space
    write_base({bba_pkg::ADDR_W{1'b1}});
    send_idle_pct = 32;
    random_phase(260);
    drain();

    write_base(bba_pkg::ADDR_W'({$urandom, $urandom}));
    send_idle_pct = 69;
    random_phase(260);
    drain();

    write_base(48'hFFFF_FFFF_FF00);
    send_idle_pct = 0;
    random_phase(280);
    drain();

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
